// File: rtl/eqs_pkg.sv
// Shared types, constants and the CORDIC angle table for the sphere point block.
package eqs_pkg;
	localparam int PIX_W = 20;
	localparam int CW = 34;
	localparam int PW = 2 * CW;
	localparam int RW = 25 + CW;
	localparam int OUT_W = 25;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [RW-1:0] OUT_LIMIT = RW'(16777215);

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;

	localparam logic [31:0] ATAN_TAB [0:23] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	// divisors already scaled (16*width, 32*height) with zero read as one
	typedef struct packed {
		logic [19:0] wdiv;
		logic [20:0] hdiv;
		logic [23:0] radius;
	} cfg_t;
endpackage

// File: rtl/eqs_front.sv
// Front end: configuration registers and divisor preparation.
module eqs_front import eqs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);
	logic [15:0] width_q, height_q;
	logic [23:0] radius_q;
	logic [15:0] w_eff, h_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 16'd2048;
			height_q <= 16'd1024;
			radius_q <= 24'd25600;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH: width_q <= cfg_data[15:0];
				REG_HEIGHT: height_q <= cfg_data[15:0];
				REG_RADIUS: radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = (width_q == 16'd0) ? 16'd1 : width_q;
	assign h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
	assign cfg.wdiv = {w_eff, 4'd0};
	assign cfg.hdiv = {h_eff, 5'd0};
	assign cfg.radius = radius_q;
endmodule

// File: rtl/eqs_fifo.sv
// Small item queue between the input port and the divider.
module eqs_fifo import eqs_pkg::*; #(
	parameter int W = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int DEPTH = 4;
	logic [W-1:0] mem_q [0:DEPTH-1];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == 3'(DEPTH));
	assign empty = (cnt_q == 3'd0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 2'd1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(do_wr) - 3'(do_rd);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'(DEPTH))
		else $error("queue count overflow");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + 3'd1)
		else $error("queue count missed a write");
	a_cnt_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> cnt_q == $past(cnt_q) - 3'd1)
		else $error("queue count missed a read");
`endif
endmodule

// File: rtl/eqs_div.sv
// Pipelined restoring divider giving the yaw and pitch angle fractions.
module eqs_div import eqs_pkg::*; #(
	parameter int ANGLE_BITS = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [PIX_W-1:0]      px,
	input  logic [PIX_W-1:0]      py,
	input  cfg_t                  cfg,
	output logic                  out_vld,
	output logic [ANGLE_BITS-1:0] yaw,
	output logic [ANGLE_BITS-1:0] pitch
);
	localparam int NB = PIX_W + ANGLE_BITS;
	localparam int A = ANGLE_BITS;

	logic          vld_s [0:NB];
	logic [20:0]   rx_s  [0:NB];
	logic [20:0]   ry_s  [0:NB];
	logic [PIX_W-1:0] dx_s [0:NB];
	logic [PIX_W-1:0] dy_s [0:NB];
	logic [A-1:0]  qx_s  [0:NB];
	logic [A-1:0]  qy_s  [0:NB];
	logic [21:0]   wd, hd;

	assign wd = {2'b00, cfg.wdiv};
	assign hd = {1'b0, cfg.hdiv};

	assign vld_s[0] = in_vld;
	assign rx_s[0] = '0;
	assign ry_s[0] = '0;
	assign dx_s[0] = px;
	assign dy_s[0] = py;
	assign qx_s[0] = '0;
	assign qy_s[0] = '0;

	for (genvar k = 0; k < NB; k++) begin : g_step
		logic [21:0] tx, ty;
		logic bx, by;
		assign tx = {rx_s[k], dx_s[k][PIX_W-1]};
		assign ty = {ry_s[k], dy_s[k][PIX_W-1]};
		assign bx = (tx >= wd);
		assign by = (ty >= hd);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k+1] <= bx ? 21'(tx - wd) : tx[20:0];
				ry_s[k+1] <= by ? 21'(ty - hd) : ty[20:0];
				dx_s[k+1] <= {dx_s[k][PIX_W-2:0], 1'b0};
				dy_s[k+1] <= {dy_s[k][PIX_W-2:0], 1'b0};
				qx_s[k+1] <= {qx_s[k][A-2:0], bx};
				qy_s[k+1] <= {qy_s[k][A-2:0], by};
			end
		end
	end

	assign out_vld = vld_s[NB];
	assign yaw = qx_s[NB] - A'(1 << (A - 1));
	assign pitch = qy_s[NB] - A'(1 << (A - 2));
endmodule

// File: rtl/eqs_back.sv
// Back end: CORDIC sine/cosine, radius scaling and output saturation.
module eqs_back import eqs_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [ANGLE_BITS-1:0] yaw,
	input  logic [ANGLE_BITS-1:0] pitch,
	input  logic [23:0]           radius,
	output logic                  out_vld,
	output logic [OUT_W-1:0]      out_x,
	output logic [OUT_W-1:0]      out_y,
	output logic [OUT_W-1:0]      out_z
);
	localparam int A = ANGLE_BITS;
	localparam int S = CORDIC_STEPS;

	logic                 vc_s [0:S];
	logic signed [CW-1:0] cx_s [0:1][0:S];
	logic signed [CW-1:0] cy_s [0:1][0:S];
	logic signed [CW-1:0] cz_s [0:1][0:S];
	logic [1:0]           qd_s [0:1][0:S];
	logic                 vq_s;
	logic signed [CW-1:0] cos_s [0:1];
	logic signed [CW-1:0] sin_s [0:1];
	logic v_m1, v_m2, v_m3, v_m4;
	logic signed [PW-1:0] psc_m1, pcc_m1;
	logic signed [CW-1:0] sp_m1, sp_m2, sc_m2, cc_m2;
	logic signed [RW-1:0] rx_m3, ry_m3, rz_m3;
	logic signed [RW-1:0] rnd_x, rnd_y, rnd_z;
	logic signed [CW:0]   rad_s;
	logic signed [PW-1:0] half_p;
	logic signed [RW-1:0] half_r;

	assign half_p = PW'(1 << 29);
	assign half_r = RW'(1 << 29);
	assign rad_s = {{(CW+1-24){1'b0}}, radius};

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [A-1:0] ang, sum, d;
		logic [1:0] quad;
		logic signed [CW-1:0] z0;
		assign ang = (l == 0) ? yaw : pitch;
		assign sum = ang + A'(1 << (A - 3));
		assign quad = sum[A-1:A-2];
		assign d = ang - {quad, {(A-2){1'b0}}};
		assign z0 = $signed({{(CW-A){d[A-1]}}, d}) <<< (32 - A);

		always_ff @(posedge clk) begin
			if (en) begin
				cx_s[l][0] <= CORDIC_GAIN;
				cy_s[l][0] <= '0;
				cz_s[l][0] <= z0;
				qd_s[l][0] <= quad;
			end
		end

		for (genvar i = 0; i < S; i++) begin : g_rot
			logic neg;
			logic signed [CW-1:0] at;
			assign neg = cz_s[l][i][CW-1];
			assign at = $signed({{(CW-32){1'b0}}, ATAN_TAB[i]});
			always_ff @(posedge clk) begin
				if (en) begin
					cx_s[l][i+1] <= neg ? cx_s[l][i] + (cy_s[l][i] >>> i)
						: cx_s[l][i] - (cy_s[l][i] >>> i);
					cy_s[l][i+1] <= neg ? cy_s[l][i] - (cx_s[l][i] >>> i)
						: cy_s[l][i] + (cx_s[l][i] >>> i);
					cz_s[l][i+1] <= neg ? cz_s[l][i] + at : cz_s[l][i] - at;
					qd_s[l][i+1] <= qd_s[l][i];
				end
			end
		end

		// quadrant fold-back
		always_ff @(posedge clk) begin
			if (en) begin
				case (qd_s[l][S])
					QUAD_0: begin
						cos_s[l] <= cx_s[l][S];
						sin_s[l] <= cy_s[l][S];
					end
					QUAD_1: begin
						cos_s[l] <= -cy_s[l][S];
						sin_s[l] <= cx_s[l][S];
					end
					QUAD_2: begin
						cos_s[l] <= -cx_s[l][S];
						sin_s[l] <= -cy_s[l][S];
					end
					default: begin
						cos_s[l] <= cy_s[l][S];
						sin_s[l] <= -cx_s[l][S];
					end
				endcase
			end
		end
	end

	assign vc_s[0] = in_vld;
	for (genvar i = 0; i < S; i++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vc_s[i+1] <= 1'b0;
			end else if (en) begin
				vc_s[i+1] <= vc_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vq_s <= 1'b0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
			v_m4 <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vq_s <= vc_s[S];
			v_m1 <= vq_s;
			v_m2 <= v_m1;
			v_m3 <= v_m2;
			v_m4 <= v_m3;
			out_vld <= v_m4;
		end
	end

	// valid chain: vc_s[i+1] lines up with cx_s[i], vq_s with cx_s[S]
	always_ff @(posedge clk) begin
		if (en) begin
			psc_m1 <= PW'(sin_s[0]) * PW'(cos_s[1]);
			pcc_m1 <= PW'(cos_s[0]) * PW'(cos_s[1]);
			sp_m1 <= sin_s[1];
			sc_m2 <= CW'((psc_m1 + half_p) >>> 30);
			cc_m2 <= CW'((pcc_m1 + half_p) >>> 30);
			sp_m2 <= sp_m1;
			rx_m3 <= RW'(rad_s) * RW'(sc_m2);
			ry_m3 <= RW'(rad_s) * RW'(sp_m2);
			rz_m3 <= RW'(rad_s) * RW'(cc_m2);
		end
	end

	assign rnd_x = -((rx_m3 + half_r) >>> 30);
	assign rnd_y = -((ry_m3 + half_r) >>> 30);
	assign rnd_z = (rz_m3 + half_r) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			out_x <= (rnd_x > OUT_LIMIT) ? OUT_W'(OUT_LIMIT)
				: (rnd_x < -OUT_LIMIT) ? OUT_W'(-OUT_LIMIT) : OUT_W'(rnd_x);
			out_y <= (rnd_y > OUT_LIMIT) ? OUT_W'(OUT_LIMIT)
				: (rnd_y < -OUT_LIMIT) ? OUT_W'(-OUT_LIMIT) : OUT_W'(rnd_y);
			out_z <= (rnd_z > OUT_LIMIT) ? OUT_W'(OUT_LIMIT)
				: (rnd_z < -OUT_LIMIT) ? OUT_W'(-OUT_LIMIT) : OUT_W'(rnd_z);
		end
	end
endmodule

// File: rtl/equirect_to_sphere_point_core.sv
// Top level: panorama vertex to sphere point, queue in, queue out.
// Usage:
//   Input side is a queue write port: an item (pixel_x, pixel_y, Q16.4) is
//   taken at a clock edge with push high and full low.
//   Result side is a queue read port: while empty is low, out_x/out_y/out_z
//   (signed Q16.8) hold the oldest result; pop with empty low takes it.
//   Config: cfg_valid/cfg_ready with cfg_index (0 width, 1 height, 2 radius)
//   and cfg_data; ready is always high, other indexes are dropped. Write
//   only while the block holds no items.
// Throughput: one item per cycle while results are popped each cycle.
// Pipeline: an item passes the divider bit steps, the angle fold, the CORDIC
//   rotation steps and the quadrant fold-back, then the angle product, its
//   rounding, the radius product and the rounded, saturated output register
//   on its way from push to empty low.
// Stall: when the result is not popped the divider and back pipelines hold and
//   the 4-entry input queue fills, then full rises.
// Reset: arst_n clears the input queue and pipeline valids; registers take
//   width 2048, height 1024, radius 25600.
module equirect_to_sphere_point_core import eqs_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [PIX_W-1:0]      pixel_x,
	input  logic [PIX_W-1:0]      pixel_y,
	output logic                  empty,
	input  logic                  pop,
	output logic [OUT_W-1:0]      out_x,
	output logic [OUT_W-1:0]      out_y,
	output logic [OUT_W-1:0]      out_z,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t cfg;
	logic q_empty, q_rd, adv;
	logic [2*PIX_W-1:0] q_data;
	logic d_vld, b_vld;
	logic [ANGLE_BITS-1:0] yaw, pitch;

	eqs_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
	);

	eqs_fifo #(.W(2 * PIX_W)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(push), .wdata({pixel_x, pixel_y}),
		.full(full), .rd(q_rd), .rdata(q_data), .empty(q_empty)
	);

	// back pipeline moves whenever its output slot is free or being popped
	assign adv = !b_vld || pop;
	assign q_rd = adv;

	eqs_div #(.ANGLE_BITS(ANGLE_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(!q_empty),
		.px(q_data[2*PIX_W-1:PIX_W]), .py(q_data[PIX_W-1:0]), .cfg(cfg),
		.out_vld(d_vld), .yaw(yaw), .pitch(pitch)
	);

	eqs_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(d_vld), .yaw(yaw),
		.pitch(pitch), .radius(cfg.radius), .out_vld(b_vld),
		.out_x(out_x), .out_y(out_y), .out_z(out_z)
	);

	assign empty = !b_vld;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(b_vld && !pop) |=> b_vld && $stable(out_x) && $stable(out_z))
		else $error("result lost while stalled");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(q_rd && !q_empty) |-> adv)
		else $error("queue read without pipeline advance");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && !q_empty) |=> !q_empty)
		else $error("queue drained during stall");
`endif
endmodule
